/* sv/infix_to_postfix_converter_assert.svh */
// ---------------------------------------------------------------------------
// Infix-to-postfix converter assertion macros
// Shared property forms for the converter's checker.
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ITP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itp assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ITP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itp assertion failed");

`endif

/* sv/itp_pkg.sv */
// ---------------------------------------------------------------------------
// Infix-to-postfix converter package
// Token codes, stack entry codes, error codes and shared types.
// ---------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [2:0] TOK_OPERAND = 3'd0;
  localparam logic [2:0] TOK_PLUS    = 3'd1;
  localparam logic [2:0] TOK_MINUS   = 3'd2;
  localparam logic [2:0] TOK_TIMES   = 3'd3;
  localparam logic [2:0] TOK_OPEN    = 3'd4;
  localparam logic [2:0] TOK_CLOSE   = 3'd5;

  localparam logic [2:0] KIND_OPERAND = 3'd0;
  localparam logic [2:0] KIND_END     = 3'd4;

  localparam logic [1:0] ST_TIMES = 2'd2;
  localparam logic [1:0] ST_OPEN  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_UNCLOSED  = 2'd3;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] entry;
  } stk_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [1:0] top;
    logic       has_open;
    logic       multi_open;
  } stk_stat_t;

  // True when the stacked top operator must be emitted before the
  // incoming operator is pushed.
  function automatic logic top_pops(input stk_stat_t st, input logic [1:0] entry);
    logic ok;
    ok = !st.empty && (st.top != ST_OPEN);
    if (entry == ST_TIMES) begin
      return ok && (st.top == ST_TIMES);
    end
    return ok;
  endfunction

  function automatic logic is_operator(input logic [2:0] func);
    return (func == TOK_PLUS) || (func == TOK_MINUS) || (func == TOK_TIMES);
  endfunction

endpackage

/* sv/itp_stack.sv */
// ---------------------------------------------------------------------------
// Infix-to-postfix operator stack
// Register stack with entry count and a count of stacked open parentheses.
// ---------------------------------------------------------------------------
module itp_stack #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  itp_pkg::stk_cmd_t   cmd,
  output itp_pkg::stk_stat_t  stat
);
  import itp_pkg::*;

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [1:0]    stk_r [STACK_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] open_r, open_nxt;
  logic [IW-1:0] wr_idx, top_idx;
  logic          full, empty;
  logic [1:0]    top;

  assign wr_idx  = cnt_r[IW-1:0];
  assign top_idx = wr_idx - 1'b1;
  assign full    = (cnt_r == CW'(STACK_DEPTH));
  assign empty   = (cnt_r == '0);
  assign top     = stk_r[top_idx];

  assign stat.empty      = empty;
  assign stat.full       = full;
  assign stat.top        = top;
  assign stat.has_open   = (open_r != '0);
  assign stat.multi_open = (open_r > CW'(1));

  always_comb begin
    cnt_nxt  = cnt_r;
    open_nxt = open_r;
    if (cmd.push && !full) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cmd.entry == ST_OPEN) begin
        open_nxt = open_r + 1'b1;
      end
    end else if (cmd.pop && !empty) begin
      cnt_nxt = cnt_r - 1'b1;
      if (top == ST_OPEN) begin
        open_nxt = open_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      open_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      stk_r[wr_idx] <= cmd.entry;
    end
  end

endmodule

/* sv/itp_ctrl.sv */
// ---------------------------------------------------------------------------
// Infix-to-postfix sequencer
// Steps one token through pops, pushes and the end flush; holds one result
// back to mark the last one; one stack operation per cycle unless stalled.
// ---------------------------------------------------------------------------
module itp_ctrl #(
  parameter int VALUE_WIDTH = itp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [2:0]             in_func,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_end,
  input  itp_pkg::stk_stat_t     stat,
  output itp_pkg::stk_cmd_t      cmd,
  input  logic                   out_free,
  output logic                   res_valid,
  output logic [2:0]             res_kind,
  output logic [VALUE_WIDTH-1:0] res_value,
  output logic                   res_last,
  output logic [1:0]             res_err
);
  import itp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TOK   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [2:0]             func_r, func_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   end_r, end_nxt;
  logic [1:0]             err_r, err_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [2:0]             pend_kind_r, pend_kind_nxt;
  logic [VALUE_WIDTH-1:0] pend_val_r, pend_val_nxt;

  logic                   can_gen, gen, finish;
  logic [2:0]             gen_kind, pop_kind;
  logic [VALUE_WIDTH-1:0] gen_val;
  logic [1:0]             entry_r, entry_in;
  logic [1:0]             tok_err, end_err, new_err;
  logic                   open_after;

  assign can_gen  = !pend_v_r || out_free;
  assign entry_r  = func_r[1:0] - 2'd1;
  assign entry_in = in_func[1:0] - 2'd1;
  assign pop_kind = {1'b0, stat.top} + 3'd1;

  // The final error of a token is known before its first result.
  always_comb begin
    tok_err    = ERR_NONE;
    open_after = stat.has_open;
    if (is_operator(in_func)) begin
      if (stat.full && !top_pops(stat, entry_in)) begin
        tok_err = ERR_OVERFLOW;
      end
    end else if (in_func == TOK_OPEN) begin
      if (stat.full) begin
        tok_err = ERR_OVERFLOW;
      end
      open_after = stat.has_open || !stat.full;
    end else if (in_func == TOK_CLOSE) begin
      if (!stat.has_open) begin
        tok_err = ERR_UNMATCHED;
      end
      open_after = stat.multi_open;
    end
    end_err = (in_end && open_after) ? ERR_UNCLOSED : ERR_NONE;
    if (err_r != ERR_NONE) begin
      new_err = err_r;
    end else if (tok_err != ERR_NONE) begin
      new_err = tok_err;
    end else begin
      new_err = end_err;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    val_nxt       = val_r;
    end_nxt       = end_r;
    err_nxt       = err_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_val_nxt  = pend_val_r;
    cmd           = '0;
    gen           = 1'b0;
    gen_kind      = KIND_OPERAND;
    gen_val       = '0;
    finish        = 1'b0;
    in_tready     = 1'b0;
    res_valid     = 1'b0;
    res_last      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid) begin
          func_nxt  = in_func;
          val_nxt   = in_value;
          end_nxt   = in_end;
          err_nxt   = new_err;
          state_nxt = S_TOK;
        end
      end
      S_TOK: begin
        case (func_r)
          TOK_OPERAND: begin
            if (can_gen) begin
              gen      = 1'b1;
              gen_kind = KIND_OPERAND;
              gen_val  = val_r;
              finish   = 1'b1;
            end
          end
          TOK_PLUS, TOK_MINUS, TOK_TIMES: begin
            if (top_pops(stat, entry_r)) begin
              if (can_gen) begin
                gen      = 1'b1;
                gen_kind = pop_kind;
                cmd.pop  = 1'b1;
              end
            end else begin
              cmd.push  = 1'b1;
              cmd.entry = entry_r;
              finish    = 1'b1;
            end
          end
          TOK_OPEN: begin
            cmd.push  = 1'b1;
            cmd.entry = ST_OPEN;
            finish    = 1'b1;
          end
          TOK_CLOSE: begin
            if (!stat.empty && (stat.top != ST_OPEN)) begin
              if (can_gen) begin
                gen      = 1'b1;
                gen_kind = pop_kind;
                cmd.pop  = 1'b1;
              end
            end else begin
              cmd.pop = !stat.empty;
              finish  = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_FLUSH: begin
        if (!stat.empty) begin
          if (stat.top == ST_OPEN) begin
            cmd.pop = 1'b1;
          end else if (can_gen) begin
            gen      = 1'b1;
            gen_kind = pop_kind;
            cmd.pop  = 1'b1;
          end
        end else if (can_gen) begin
          gen       = 1'b1;
          gen_kind  = KIND_END;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend_v_r || out_free) begin
          res_valid  = pend_v_r;
          res_last   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
          if (end_r) begin
            err_nxt = ERR_NONE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = end_r ? S_FLUSH : S_DONE;
    end
    if (gen) begin
      res_valid     = pend_v_r;
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = gen_kind;
      pend_val_nxt  = gen_val;
    end
  end

  assign res_kind  = pend_kind_r;
  assign res_value = pend_val_r;
  assign res_err   = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      err_r    <= ERR_NONE;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      err_r    <= err_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    val_r       <= val_nxt;
    end_r       <= end_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_val_r  <= pend_val_nxt;
  end

endmodule

/* sv/infix_to_postfix_converter.sv */
// ---------------------------------------------------------------------------
// Infix-to-postfix converter
// Shunting-yard conversion of an infix token stream into postfix tokens.
// ---------------------------------------------------------------------------
// One token is taken at a time and the block is busy until all of its
// results have been handed to the output register. The operator stack is
// read and updated at its top, one operation per cycle while the output
// side is free, so every operator that a token emits from the stack and
// every open parenthesis that the end flush discards adds a step; a token
// marked with tlast also emits an end marker. Stalls on the output side
// hold these steps. Results carry the final error state of the token
// that caused them, and tlast marks the last of them.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = itp_pkg::VALUE_WIDTH_DEF,
  localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // operand_value
  input  logic [2:0]        in_tuser,   // func
  input  logic              in_tlast,   // expr_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // out_value
  output logic [4:0]        out_tuser,  // out_kind, error_code
  output logic              out_tlast   // out_last
);
  import itp_pkg::*;

  stk_cmd_t               cmd;
  stk_stat_t              stat;
  logic                   out_free;
  logic                   res_valid, res_last;
  logic [2:0]             res_kind;
  logic [1:0]             res_err;
  logic [VALUE_WIDTH-1:0] res_value;

  logic                   out_valid_r;
  logic [DATA_W-1:0]      out_data_r;
  logic [4:0]             out_user_r;
  logic                   out_last_r;

  itp_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  itp_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .in_value  (in_tdata[VALUE_WIDTH-1:0]),
    .in_end    (in_tlast),
    .stat      (stat),
    .cmd       (cmd),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_kind  (res_kind),
    .res_value (res_value),
    .res_last  (res_last),
    .res_err   (res_err)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= DATA_W'(res_value);
      out_user_r <= {res_err, res_kind};
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/itp_checker.sv */
// ---------------------------------------------------------------------------
// Infix-to-postfix converter checker
// Port-level properties of the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module itp_checker #(
  parameter int DATA_W = 32
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic [4:0]        out_tuser,
  input logic              out_tlast
);
  import itp_pkg::*;

  `ITP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `ITP_ASSERT_NOW(a_end_is_last, out_tvalid && (out_tuser[2:0] == KIND_END), out_tlast)
  `ITP_ASSERT_NOW(a_no_value_on_ops,
                  out_tvalid && (out_tuser[2:0] != KIND_OPERAND), out_tdata == '0)
  `ITP_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind infix_to_postfix_converter itp_checker #(
  .DATA_W (DATA_W)
) u_itp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
